### hdl/paf_pkg.sv
`default_nettype none
package paf_pkg;

   localparam int POS_W      = 20;
   localparam int ACC_W      = 24;
   localparam int OFF_W      = POS_W + 1;
   localparam int DIST_W     = 2 * OFF_W;
   localparam int MAG_W      = ACC_W;
   localparam int FRAC_SHIFT = 20;
   localparam int NUM_W      = MAG_W + FRAC_SHIFT;
   localparam int PROD_W     = OFF_W + ACC_W;
   localparam int TERM_SHIFT = 10;
   localparam int TERM_W     = PROD_W - TERM_SHIFT;
   localparam int SUM_W      = TERM_W + 1;

   localparam int WORD_W     = 64;
   localparam int WORD_REGS  = 4;
   localparam int WORD_IDX_W = 2;
   localparam int CNT_W      = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int MAX_ATTRACTORS_DEFAULT = 4;

   localparam int FRONT_LAT  = 3;
   localparam int DIV_LAT    = NUM_W + 1;
   localparam int SIDE_DEPTH = FRONT_LAT + DIV_LAT;

   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_0 = 3'd1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic signed [OFF_W-1:0]  ox;
      logic signed [OFF_W-1:0]  oy;
      logic        [DIST_W-1:0] d;
      logic        [MAG_W-1:0]  mag;
      logic                     neg;
   } paf_front_type;

   typedef struct packed {
      logic signed [OFF_W-1:0] ox;
      logic signed [OFF_W-1:0] oy;
      logic signed [ACC_W-1:0] q;
      logic                    satq;
      logic                    zero;
   } paf_quot_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] accx;
      logic signed [ACC_W-1:0] accy;
      logic                    last;
   } paf_side_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] tx;
      logic signed [TERM_W-1:0] ty;
      logic                     zero;
      logic                     satq;
   } paf_term_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] accx;
      logic signed [ACC_W-1:0] accy;
      logic                    sat;
      logic                    sing;
      logic                    last;
   } paf_sum_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] value;
      logic                    clamped;
   } paf_clamp_type;

   function automatic paf_clamp_type clamp_acc(input logic signed [SUM_W-1:0] v);
      paf_clamp_type r;
      r.clamped = 1'b0;
      r.value   = v[ACC_W-1:0];
      if (v > SUM_W'(ACC_MAX)) begin
         r.value   = ACC_MAX;
         r.clamped = 1'b1;
      end else if (v < SUM_W'(ACC_MIN)) begin
         r.value   = ACC_MIN;
         r.clamped = 1'b1;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

### hdl/paf_front.sv
`default_nettype none
module paf_front (
   input  wire logic                               clock,
   input  wire logic signed [paf_pkg::POS_W-1:0]  pos_x,
   input  wire logic signed [paf_pkg::POS_W-1:0]  pos_y,
   input  wire logic        [paf_pkg::WORD_W-1:0] word,
   output paf_pkg::paf_front_type                  front
);
   localparam int PW = paf_pkg::POS_W;
   localparam int AW = paf_pkg::ACC_W;
   localparam int OW = paf_pkg::OFF_W;
   localparam int DW = paf_pkg::DIST_W;

   logic signed [PW-1:0] ax, ay;
   logic signed [AW-1:0] s;
   paf_pkg::paf_front_type s1_in, s1_ff, s2_ff, s3_in, s3_ff;
   logic [DW-1:0] sqx_in, sqy_in, sqx_ff, sqy_ff;

   assign ax = word[PW-1:0];
   assign ay = word[2*PW-1:PW];
   assign s  = word[2*PW+AW-1:2*PW];

   always_comb begin
      s1_in     = '0;
      s1_in.ox  = OW'(ax) - OW'(pos_x);
      s1_in.oy  = OW'(ay) - OW'(pos_y);
      s1_in.neg = s[AW-1];
      s1_in.mag = s[AW-1] ? AW'(-s) : AW'(s);
   end

   assign sqx_in = DW'(s1_ff.ox) * DW'(s1_ff.ox);
   assign sqy_in = DW'(s1_ff.oy) * DW'(s1_ff.oy);

   always_comb begin
      s3_in   = s2_ff;
      s3_in.d = sqx_ff + sqy_ff;
   end

   always_ff @(posedge clock) begin
      s1_ff    <= s1_in;
      s2_ff    <= s1_ff;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      s3_ff    <= s3_in;
   end

   assign front = s3_ff;
endmodule
`default_nettype wire

### hdl/paf_div.sv
`default_nettype none
module paf_div (
   input  wire logic               clock,
   input  wire paf_pkg::paf_front_type front,
   output paf_pkg::paf_quot_type   quot
);
   localparam int NW = paf_pkg::NUM_W;
   localparam int DW = paf_pkg::DIST_W;
   localparam int MW = paf_pkg::MAG_W;
   localparam int AW = paf_pkg::ACC_W;

   typedef struct packed {
      logic [DW-1:0]                   rem;
      logic [NW-1:0]                   qbits;
      paf_pkg::paf_front_type          f;
      logic                            zero;
   } paf_div_type;

   paf_div_type st0;
   paf_div_type st_ff [1:NW];
   paf_div_type st_in [NW];
   paf_pkg::paf_quot_type quot_in, quot_ff;

   always_comb begin
      st0      = '0;
      st0.f    = front;
      st0.zero = (front.d == '0);
   end

   // one quotient bit per stage, numerator = mag << 20
   for (genvar k = 0; k < NW; k++) begin : g_stage
      paf_div_type   cur;
      logic          nbit;
      logic [DW:0]   r2;
      logic          ge;
      if (k == 0) begin : g_first
         assign cur = st0;
      end else begin : g_next
         assign cur = st_ff[k];
      end
      if (k < MW) begin : g_bit
         assign nbit = cur.f.mag[MW-1-k];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      assign r2 = {cur.rem, nbit};
      assign ge = (r2 >= {1'b0, cur.f.d});
      always_comb begin
         st_in[k]       = cur;
         st_in[k].rem   = ge ? DW'(r2 - {1'b0, cur.f.d}) : DW'(r2);
         st_in[k].qbits = {cur.qbits[NW-2:0], ge};
      end
      always_ff @(posedge clock) begin
         st_ff[k+1] <= st_in[k];
      end
   end

   always_comb begin
      logic [NW-1:0] qm;
      qm           = st_ff[NW].qbits;
      quot_in      = '0;
      quot_in.ox   = st_ff[NW].f.ox;
      quot_in.oy   = st_ff[NW].f.oy;
      quot_in.zero = st_ff[NW].zero;
      if (st_ff[NW].f.neg) begin
         if (qm > NW'(-$signed(NW'(paf_pkg::ACC_MIN)))) begin
            qm           = NW'(-$signed(NW'(paf_pkg::ACC_MIN)));
            quot_in.satq = 1'b1;
         end
         quot_in.q = AW'(-qm[AW-1:0]);
      end else begin
         if (qm > NW'(paf_pkg::ACC_MAX)) begin
            qm           = NW'(paf_pkg::ACC_MAX);
            quot_in.satq = 1'b1;
         end
         quot_in.q = qm[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
endmodule
`default_nettype wire

### hdl/paf_accum.sv
`default_nettype none
module paf_accum #(
   parameter int LANES = paf_pkg::MAX_ATTRACTORS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        valid,
   input  wire paf_pkg::paf_side_type       side,
   input  wire paf_pkg::paf_quot_type       quot [LANES],
   input  wire logic [paf_pkg::CNT_W-1:0]   count,
   output logic                             out_valid,
   output paf_pkg::paf_sum_type             sum
);
   localparam int PW = paf_pkg::PROD_W;
   localparam int TS = paf_pkg::TERM_SHIFT;
   localparam int SW = paf_pkg::SUM_W;
   localparam int CW = paf_pkg::CNT_W;

   paf_pkg::paf_term_type term_ff [LANES+1][LANES];
   paf_pkg::paf_sum_type  sum_ff  [LANES+1];
   paf_pkg::paf_sum_type  sum_in  [LANES];
   logic [LANES:0]        vld_ff;

   for (genvar l = 0; l < LANES; l++) begin : g_prod
      logic signed [PW-1:0] px, py;
      assign px = quot[l].ox * quot[l].q;
      assign py = quot[l].oy * quot[l].q;
      always_ff @(posedge clock) begin
         term_ff[0][l].tx   <= px[PW-1:TS];
         term_ff[0][l].ty   <= py[PW-1:TS];
         term_ff[0][l].zero <= quot[l].zero;
         term_ff[0][l].satq <= quot[l].satq;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff[0].accx <= side.accx;
      sum_ff[0].accy <= side.accy;
      sum_ff[0].sat  <= 1'b0;
      sum_ff[0].sing <= 1'b0;
      sum_ff[0].last <= side.last;
   end

   // attractors applied in index order, one per stage
   for (genvar a = 0; a < LANES; a++) begin : g_chain
      paf_pkg::paf_clamp_type cx, cy;
      assign cx = paf_pkg::clamp_acc(SW'(sum_ff[a].accx) + SW'(term_ff[a][a].tx));
      assign cy = paf_pkg::clamp_acc(SW'(sum_ff[a].accy) + SW'(term_ff[a][a].ty));
      always_comb begin
         sum_in[a] = sum_ff[a];
         if (CW'(a) < count) begin
            if (term_ff[a][a].zero) begin
               sum_in[a].sing = 1'b1;
            end else begin
               sum_in[a].accx = cx.value;
               sum_in[a].accy = cy.value;
               sum_in[a].sat  = sum_ff[a].sat | term_ff[a][a].satq
                                | cx.clamped | cy.clamped;
            end
         end
      end
      always_ff @(posedge clock) begin
         sum_ff[a+1]  <= sum_in[a];
         term_ff[a+1] <= term_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LANES-1:0], valid};
      end
   end

   assign out_valid = vld_ff[LANES];
   assign sum       = sum_ff[LANES];
endmodule
`default_nettype wire

### hdl/particle_attractor_force.sv
`default_nettype none
// Point-attractor force for a particle stream. One request per clock: each
// request (position, acceleration, last mark) flows through a fixed pipeline
// and its result appears on the rsp_ ports, marked by rsp_strobe for one
// cycle, LANES being the smaller of MAX_ATTRACTORS and 4. The receiver cannot
// stall, so busy is always low and start may be held high every cycle. The
// pipeline is the input register, three offset/distance stages, the
// per-attractor restoring divider (44 stages, one quotient bit each) and its
// output register, one product stage, and the in-order accumulation chain
// (one stage per attractor). Configuration (attractor count and words) is
// written through the csr_ port, always ready, and must only change while no
// request is in flight.
module particle_attractor_force #(
   parameter int MAX_ATTRACTORS = paf_pkg::MAX_ATTRACTORS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [paf_pkg::POS_W-1:0]     req_pos_x,
   input  wire logic signed [paf_pkg::POS_W-1:0]     req_pos_y,
   input  wire logic signed [paf_pkg::ACC_W-1:0]     req_accel_x_in,
   input  wire logic signed [paf_pkg::ACC_W-1:0]     req_accel_y_in,
   input  wire logic                                  req_last_particle,
   // result channel
   output logic                                       rsp_strobe,
   output logic signed [paf_pkg::ACC_W-1:0]          rsp_accel_x_out,
   output logic signed [paf_pkg::ACC_W-1:0]          rsp_accel_y_out,
   output logic                                       rsp_saturated,
   output logic                                       rsp_singular,
   output logic                                       rsp_last_out,
   // configuration
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [paf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [paf_pkg::WORD_W-1:0]           csr_data
);
   localparam int LANES = (MAX_ATTRACTORS < paf_pkg::WORD_REGS) ?
                          MAX_ATTRACTORS : paf_pkg::WORD_REGS;
   localparam int CW    = paf_pkg::CNT_W;
   localparam int SD    = paf_pkg::SIDE_DEPTH;

   // configuration registers
   logic [CW-1:0]                 count_ff;
   logic [paf_pkg::WORD_W-1:0]    word_ff [paf_pkg::WORD_REGS];
   logic [CW-1:0]                 lanes_used;
   logic [paf_pkg::CSR_IDX_W-1:0] word_sel;

   assign csr_ready = 1'b1;
   assign word_sel  = csr_index - paf_pkg::CSR_WORD_0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < paf_pkg::WORD_REGS; i++) word_ff[i] <= '0;
      end else if (csr_valid) begin
         if (csr_index == paf_pkg::CSR_COUNT) begin
            count_ff <= csr_data[CW-1:0];
         end else if (csr_index >= paf_pkg::CSR_WORD_0 &&
                      csr_index < paf_pkg::CSR_WORD_0 +
                                  paf_pkg::CSR_IDX_W'(paf_pkg::WORD_REGS)) begin
            word_ff[word_sel[paf_pkg::WORD_IDX_W-1:0]] <= csr_data;
         end
      end
   end

   // count limited to the lanes that exist
   assign lanes_used = (count_ff > CW'(LANES)) ? CW'(LANES) : count_ff;

   // input register
   logic                         in_vld_ff;
   logic signed [paf_pkg::POS_W-1:0] px_ff, py_ff;
   paf_pkg::paf_side_type        in_side_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= start & ~busy;
      px_ff           <= req_pos_x;
      py_ff           <= req_pos_y;
      in_side_ff.accx <= req_accel_x_in;
      in_side_ff.accy <= req_accel_y_in;
      in_side_ff.last <= req_last_particle;
   end

   // per-attractor lanes: offsets and distance, then divider
   paf_pkg::paf_front_type front [LANES];
   paf_pkg::paf_quot_type  quot  [LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      paf_front u_front (
         .clock (clock),
         .pos_x (px_ff),
         .pos_y (py_ff),
         .word  (word_ff[l]),
         .front (front[l])
      );
      paf_div u_div (
         .clock (clock),
         .front (front[l]),
         .quot  (quot[l])
      );
   end

   // acceleration and valid ride alongside the lanes
   paf_pkg::paf_side_type side_ff [SD];
   logic [SD-1:0]         side_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) side_vld_ff <= '0;
      else       side_vld_ff <= {side_vld_ff[SD-2:0], in_vld_ff};
      side_ff[0] <= in_side_ff;
      for (int i = 1; i < SD; i++) side_ff[i] <= side_ff[i-1];
   end

   paf_pkg::paf_sum_type sum;

   paf_accum #(.LANES(LANES)) u_accum (
      .clock     (clock),
      .reset     (reset),
      .valid     (side_vld_ff[SD-1]),
      .side      (side_ff[SD-1]),
      .quot      (quot),
      .count     (lanes_used),
      .out_valid (rsp_strobe),
      .sum       (sum)
   );

   assign rsp_accel_x_out = sum.accx;
   assign rsp_accel_y_out = sum.accy;
   assign rsp_saturated   = sum.sat;
   assign rsp_singular    = sum.sing;
   assign rsp_last_out    = sum.last;
endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One particle request: position, input acceleration and last mark.
   typedef struct {
      logic signed [paf_pkg::POS_W-1:0] px;
      logic signed [paf_pkg::POS_W-1:0] py;
      logic signed [paf_pkg::ACC_W-1:0] ax;
      logic signed [paf_pkg::ACC_W-1:0] ay;
      logic                             last;
   } particle_req_type;

   typedef struct {
      logic signed [paf_pkg::ACC_W-1:0] ax;
      logic signed [paf_pkg::ACC_W-1:0] ay;
      logic                             sat;
      logic                             sing;
      logic                             last;
   } accel_result_type;

   localparam int IDLE_LIMIT = 2000;

   logic clock, reset;
   logic start, busy;
   logic signed [paf_pkg::POS_W-1:0] req_pos_x, req_pos_y;
   logic signed [paf_pkg::ACC_W-1:0] req_accel_x_in, req_accel_y_in;
   logic req_last_particle;
   logic rsp_strobe;
   logic signed [paf_pkg::ACC_W-1:0] rsp_accel_x_out, rsp_accel_y_out;
   logic rsp_saturated, rsp_singular, rsp_last_out;
   logic csr_valid, csr_ready;
   logic [paf_pkg::CSR_IDX_W-1:0] csr_index;
   logic [paf_pkg::WORD_W-1:0] csr_data;

   particle_attractor_force uut (.*);

   // Shadow copy of the attractor registers.
   logic [paf_pkg::CNT_W-1:0]  attr_count;
   logic [paf_pkg::WORD_W-1:0] attr_word [paf_pkg::WORD_REGS];

   particle_req_type particle_q[$];   // waiting to be sent
   accel_result_type accel_q[$];      // expected results, oldest first
   int errors;
   int idle_cycles;
   int gap_left, burst_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp_acc24(longint v, inout logic flag);
      if (v > longint'(paf_pkg::ACC_MAX)) begin
         flag = 1'b1;
         return longint'(paf_pkg::ACC_MAX);
      end
      if (v < longint'(paf_pkg::ACC_MIN)) begin
         flag = 1'b1;
         return longint'(paf_pkg::ACC_MIN);
      end
      return v;
   endfunction

   // Sum the pull of every attractor in use, in index order.
   function automatic accel_result_type apply_attractors(particle_req_type p);
      longint accx, accy, ox, oy, s, d, mag, qm, q;
      int n;
      logic [paf_pkg::WORD_W-1:0] w;
      accel_result_type r;
      accx = p.ax;
      accy = p.ay;
      r.sat = 1'b0;
      r.sing = 1'b0;
      n = (attr_count > paf_pkg::WORD_REGS) ? paf_pkg::WORD_REGS : attr_count;
      for (int i = 0; i < n; i++) begin
         w = attr_word[paf_pkg::WORD_IDX_W'(i)];
         ox = $signed(w[19:0]);
         ox = ox - p.px;
         oy = $signed(w[39:20]);
         oy = oy - p.py;
         s = $signed(w[63:40]);
         d = ox * ox + oy * oy;
         if (d == 0) begin
            r.sing = 1'b1;   // particle sits on the attractor: skip it
            continue;
         end
         mag = (s < 0) ? -s : s;
         qm = (mag << 20) / d;
         if (s < 0) begin
            if (qm > 64'd8388608) begin
               qm = 8388608;
               r.sat = 1'b1;
            end
            q = -qm;
         end else begin
            if (qm > longint'(paf_pkg::ACC_MAX)) begin
               qm = longint'(paf_pkg::ACC_MAX);
               r.sat = 1'b1;
            end
            q = qm;
         end
         // >>> on a signed longint floors, as the datapath does
         accx = clamp_acc24(accx + ((ox * q) >>> 10), r.sat);
         accy = clamp_acc24(accy + ((oy * q) >>> 10), r.sat);
      end
      r.ax = accx[paf_pkg::ACC_W-1:0];
      r.ay = accy[paf_pkg::ACC_W-1:0];
      r.last = p.last;
      return r;
   endfunction

   // Sender: bursts of requests separated by random gaps.
   always @(posedge clock) begin
      particle_req_type p;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
         burst_left <= 1;
      end else begin
         if (start && !busy) begin
            p.px = req_pos_x;
            p.py = req_pos_y;
            p.ax = req_accel_x_in;
            p.ay = req_accel_y_in;
            p.last = req_last_particle;
            accel_q.insert(accel_q.size(), apply_attractors(p));
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (particle_q.size() > 0) begin
               p = particle_q.pop_front();
               req_pos_x <= p.px;
               req_pos_y <= p.py;
               req_accel_x_in <= p.ax;
               req_accel_y_in <= p.ay;
               req_last_particle <= p.last;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  // mostly short gaps, sometimes none, now and then long
                  case ($urandom_range(0, 3))
                     0: gap_left <= 0;
                     1, 2: gap_left <= $urandom_range(1, 4);
                     default: gap_left <= $urandom_range(5, 30);
                  endcase
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result checker and watchdog.
   always @(posedge clock) begin
      accel_result_type e;
      if (!reset) begin
         if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
         if (rsp_strobe) begin
            if (accel_q.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               e = accel_q.pop_front();
               if (rsp_accel_x_out !== e.ax) begin
                  $error("accel_x_out: expected %0d, got %0d", e.ax, rsp_accel_x_out);
                  errors++;
               end
               if (rsp_accel_y_out !== e.ay) begin
                  $error("accel_y_out: expected %0d, got %0d", e.ay, rsp_accel_y_out);
                  errors++;
               end
               if (rsp_saturated !== e.sat) begin
                  $error("saturated: expected %0b, got %0b", e.sat, rsp_saturated);
                  errors++;
               end
               if (rsp_singular !== e.sing) begin
                  $error("singular: expected %0b, got %0b", e.sing, rsp_singular);
                  errors++;
               end
               if (rsp_last_out !== e.last) begin
                  $error("last_out: expected %0b, got %0b", e.last, rsp_last_out);
                  errors++;
               end
            end
         end
      end else begin
         idle_cycles <= 0;
      end
   end

   // Register write; the shadow copy follows the write. Indexes past the last
   // attractor word are dropped by the block.
   task automatic write_csr(logic [paf_pkg::CSR_IDX_W-1:0] idx,
                            logic [paf_pkg::WORD_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == paf_pkg::CSR_COUNT)
         attr_count = value[paf_pkg::CNT_W-1:0];
      else if (idx < paf_pkg::CSR_WORD_0 + paf_pkg::WORD_REGS)
         attr_word[paf_pkg::WORD_IDX_W'(idx - paf_pkg::CSR_WORD_0)] = value;
   endtask

   function automatic logic [paf_pkg::WORD_W-1:0] pack_attractor(logic [19:0] x,
         logic [19:0] y, logic [23:0] strength);
      return {strength, y, x};
   endfunction

   function automatic logic [paf_pkg::WORD_W-1:0] random_attractor();
      logic [paf_pkg::WORD_W-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: ;                                                   // fully random
         1: w[63:40] = ($urandom_range(0, 1)) ? paf_pkg::ACC_MAX : paf_pkg::ACC_MIN;
         default: w[63:40] = 24'($signed($urandom_range(0, 8192)) - 4096);
      endcase
      if ($urandom_range(0, 2) == 0) begin   // cluster near the origin
         w[19:0] = 20'($signed($urandom_range(0, 4096)) - 2048);
         w[39:20] = 20'($signed($urandom_range(0, 4096)) - 2048);
      end
      return w;
   endfunction

   function automatic particle_req_type random_particle();
      particle_req_type p;
      logic [paf_pkg::WORD_IDX_W-1:0] a;
      p.px = paf_pkg::POS_W'($urandom);
      p.py = paf_pkg::POS_W'($urandom);
      p.ax = paf_pkg::ACC_W'($urandom);
      p.ay = paf_pkg::ACC_W'($urandom);
      p.last = 1'($urandom_range(0, 1));
      a = paf_pkg::WORD_IDX_W'($urandom_range(0, paf_pkg::WORD_REGS - 1));
      case ($urandom_range(0, 7))
         0: begin   // exactly on an attractor
            p.px = attr_word[a][19:0];
            p.py = attr_word[a][39:20];
         end
         1, 2, 3: begin   // close in, where the pull is strong
            p.px = attr_word[a][19:0] + 20'($signed($urandom_range(0, 64)) - 32);
            p.py = attr_word[a][39:20] + 20'($signed($urandom_range(0, 64)) - 32);
         end
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0)
         p.ax = 24'($signed($urandom_range(0, 2048)) - 1024);
      if ($urandom_range(0, 7) == 0)
         p.ay = ($urandom_range(0, 1)) ? paf_pkg::ACC_MAX : paf_pkg::ACC_MIN;
      return p;
   endfunction

   // Let the queue drain and every expected result come back.
   task automatic drain();
      do @(posedge clock); while (particle_q.size() || start || accel_q.size());
   endtask

   task automatic add_particle(logic [19:0] x, logic [19:0] y, logic [23:0] ax,
                               logic [23:0] ay, logic last);
      particle_req_type p;
      p.px = x;
      p.py = y;
      p.ax = ax;
      p.ay = ay;
      p.last = last;
      particle_q.insert(particle_q.size(), p);
   endtask

   initial begin
      errors = 0;
      attr_count = '0;
      foreach (attr_word[i]) attr_word[i] = '0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      start = 1'b0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_accel_x_in = '0;
      req_accel_y_in = '0;
      req_last_particle = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Requests with no attractor in use pass straight through.
      add_particle(20'h7FFFF, 20'h80000, paf_pkg::ACC_MAX, paf_pkg::ACC_MIN, 1'b1);
      add_particle(20'h80000, 20'h7FFFF, paf_pkg::ACC_MIN, paf_pkg::ACC_MAX, 1'b0);
      drain();

      // Directed set: strongest pulls of both signs, corner positions.
      write_csr(paf_pkg::CSR_WORD_0, pack_attractor(20'd0, 20'd0, paf_pkg::ACC_MAX));
      write_csr(paf_pkg::CSR_WORD_0 + 3'd1,
                pack_attractor(20'd1024, 20'd0, paf_pkg::ACC_MIN));
      write_csr(paf_pkg::CSR_WORD_0 + 3'd2,
                pack_attractor(20'h7FFFF, 20'h7FFFF, 24'd4096));
      write_csr(paf_pkg::CSR_WORD_0 + 3'd3,
                pack_attractor(20'h80000, 20'h80000, 24'hFFF000));
      write_csr(paf_pkg::CSR_COUNT, 64'd4);
      add_particle(20'd0, 20'd0, 24'd0, 24'd0, 1'b0);          // on attractor 0
      add_particle(20'd1024, 20'd0, 24'd0, 24'd0, 1'b1);       // on attractor 1
      add_particle(20'd1, 20'd0, 24'd0, 24'd0, 1'b0);          // tiny distance
      add_particle(20'd0, 20'hFFFFF, paf_pkg::ACC_MAX, paf_pkg::ACC_MAX, 1'b0); // clamps high
      add_particle(20'd2048, 20'd1, paf_pkg::ACC_MIN, paf_pkg::ACC_MIN, 1'b0);  // clamps low
      add_particle(20'h7FFFF, 20'h7FFFF, 24'd0, 24'd0, 1'b1);  // on attractor 2
      add_particle(20'h80000, 20'h80000, 24'd5, 24'hFFFFFB, 1'b0); // on attractor 3
      add_particle(20'h80000, 20'h7FFFF, 24'd0, 24'd0, 1'b0);  // farthest corner
      add_particle(20'h7FFFF, 20'h80000, paf_pkg::ACC_MAX, paf_pkg::ACC_MIN, 1'b1);
      add_particle(20'd512, 20'd512, 24'd100, 24'hFFFF9C, 1'b0);
      add_particle(20'h40000, 20'hC0000, 24'd0, 24'd0, 1'b0);
      add_particle(20'd0, 20'd1024, 24'd0, 24'd0, 1'b1);
      drain();

      // Count past the number of words is limited to four.
      write_csr(paf_pkg::CSR_COUNT, 64'd7);
      add_particle(20'd0, 20'd0, 24'd0, 24'd0, 1'b0);
      add_particle(20'd3, 20'hFFFFD, 24'd7, 24'd9, 1'b1);
      drain();
      // Writes past the last word must be ignored.
      for (int i = 0; i < 3; i++)
         write_csr(paf_pkg::CSR_WORD_0 + paf_pkg::CSR_IDX_W'(paf_pkg::WORD_REGS + i),
                   {$urandom, $urandom});
      add_particle(20'd100, 20'd200, 24'd300, 24'd400, 1'b0);
      drain();

      // Random phases, each with a fresh attractor setup.
      for (int ph = 0; ph < 8; ph++) begin
         for (int i = 0; i < paf_pkg::WORD_REGS; i++)
            write_csr(paf_pkg::CSR_WORD_0 + paf_pkg::CSR_IDX_W'(i), random_attractor());
         case (ph)
            0: write_csr(paf_pkg::CSR_COUNT, 64'd1);
            1: write_csr(paf_pkg::CSR_COUNT, 64'd0);
            2: write_csr(paf_pkg::CSR_COUNT, 64'd7);
            3: write_csr(paf_pkg::CSR_COUNT, {$urandom, $urandom});   // upper bits dropped
            default: write_csr(paf_pkg::CSR_COUNT, 64'($urandom_range(1, 5)));
         endcase
         for (int i = 0; i < 48; i++)
            particle_q.insert(particle_q.size(), random_particle());
         drain();
      end

      repeat (60) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
`default_nettype wire
